### rtl/core/thermostat_bang_bang_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thermostat controller
// Shared forms for concurrent checks, clocked on clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_BANG_BANG_CONTROLLER_UNIT_ASSERT_SVH
`define THERMOSTAT_BANG_BANG_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tbbc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat controller package
// Widths, state and event codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbbc_pkg;

   // Temperature sample width (valid range 8 to 32).
   localparam int TempWidth     = 16;
   localparam int DeadbandWidth = 10;
   localparam int TickWidth     = 16;
   localparam int FaultWidth    = 8;
   localparam int ModeWidth     = 3;
   localparam int OpWidth       = 2;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = (TempWidth > TickWidth) ? TempWidth : TickWidth;

   // Compare width: room for setpoint plus or minus deadband and reading deltas.
   localparam int CalcWidth =
      ((TempWidth > DeadbandWidth) ? TempWidth : DeadbandWidth) + 2;

   // Controller states, also driven out as the mode.
   localparam logic [ModeWidth-1:0] ST_WAIT       = 3'd0;
   localparam logic [ModeWidth-1:0] ST_CHECK      = 3'd1;
   localparam logic [ModeWidth-1:0] ST_COOL       = 3'd2;
   localparam logic [ModeWidth-1:0] ST_COOL_SENSE = 3'd3;
   localparam logic [ModeWidth-1:0] ST_HEAT       = 3'd4;
   localparam logic [ModeWidth-1:0] ST_HEAT_SENSE = 3'd5;

   // Event codes.
   localparam logic [OpWidth-1:0] EV_NONE  = 2'd0;
   localparam logic [OpWidth-1:0] EV_TICK  = 2'd1;
   localparam logic [OpWidth-1:0] EV_READY = 2'd2;
   localparam logic [OpWidth-1:0] EV_ENTRY = 2'd3;

   // Register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_SETPOINT    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEADBAND    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DRIVE_TICKS = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_REST_TICKS  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ERROR_LIMIT = 3'd4;

   // Register reset values.
   localparam logic [TickWidth-1:0]  DRIVE_TICKS_RESET = 16'd10;
   localparam logic [TickWidth-1:0]  REST_TICKS_RESET  = 16'd5;
   localparam logic [FaultWidth-1:0] ERROR_LIMIT_RESET = 8'd5;
   localparam logic [FaultWidth-1:0] FAULT_MAX         = 8'hFF;

   // One event presented to the controller core.
   typedef struct packed {
      logic                        valid;
      logic [OpWidth-1:0]          operation;
      logic signed [TempWidth-1:0] temperature;
   } step_type;

   // One result word from the controller core.
   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic                 request_measure;
      logic                 error_pulse;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/tbbc_ctrl.sv
// ----------------------------------------------------------------------------
// Thermostat controller core
// Holds configuration and control state; evaluates one valid event per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbbc_ctrl (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      csr_write_enable,
   input  wire [tbbc_pkg::CsrIndexWidth-1:0]        csr_index,
   input  wire [tbbc_pkg::CsrDataWidth-1:0]         csr_wdata,
   input  tbbc_pkg::step_type                       step,
   output tbbc_pkg::result_type                     result
);

   // Configuration registers.
   logic signed [tbbc_pkg::TempWidth-1:0]  setpoint_ff;
   logic [tbbc_pkg::DeadbandWidth-1:0]     deadband_ff;
   logic [tbbc_pkg::TickWidth-1:0]         drive_ticks_ff;
   logic [tbbc_pkg::TickWidth-1:0]         rest_ticks_ff;
   logic [tbbc_pkg::FaultWidth-1:0]        error_limit_ff;

   // Control state.
   logic [tbbc_pkg::ModeWidth-1:0]         state_ff, state_in;
   logic [tbbc_pkg::TickWidth-1:0]         count_ff, count_in;
   logic signed [tbbc_pkg::TempWidth-1:0]  reading_ff, reading_in;
   logic [tbbc_pkg::FaultWidth-1:0]        fault_ff, fault_in;

   // Extended operands for the compares.
   logic signed [tbbc_pkg::CalcWidth-1:0]  sp_ext, db_ext, temp_ext, old_ext;
   logic signed [tbbc_pkg::CalcWidth-1:0]  band_hi, band_lo, delta;
   logic                                   above_band, below_band;
   logic                                   cool_effective, heat_effective;
   logic [tbbc_pkg::FaultWidth-1:0]        fault_inc;
   logic                                   request_measure, error_pulse;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff    <= '0;
         deadband_ff    <= '0;
         drive_ticks_ff <= tbbc_pkg::DRIVE_TICKS_RESET;
         rest_ticks_ff  <= tbbc_pkg::REST_TICKS_RESET;
         error_limit_ff <= tbbc_pkg::ERROR_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tbbc_pkg::CSR_SETPOINT: begin
               setpoint_ff <= $signed(csr_wdata[tbbc_pkg::TempWidth-1:0]);
            end
            tbbc_pkg::CSR_DEADBAND: begin
               deadband_ff <= csr_wdata[tbbc_pkg::DeadbandWidth-1:0];
            end
            tbbc_pkg::CSR_DRIVE_TICKS: begin
               drive_ticks_ff <= csr_wdata[tbbc_pkg::TickWidth-1:0];
            end
            tbbc_pkg::CSR_REST_TICKS: begin
               rest_ticks_ff <= csr_wdata[tbbc_pkg::TickWidth-1:0];
            end
            tbbc_pkg::CSR_ERROR_LIMIT: begin
               error_limit_ff <= csr_wdata[tbbc_pkg::FaultWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Band limits and the change since the last reading.
   assign sp_ext   = $signed({{(tbbc_pkg::CalcWidth-tbbc_pkg::TempWidth){setpoint_ff[
                        tbbc_pkg::TempWidth-1]}}, setpoint_ff});
   assign db_ext   = $signed({{(tbbc_pkg::CalcWidth-tbbc_pkg::DeadbandWidth){1'b0}},
                        deadband_ff});
   assign temp_ext = $signed({{(tbbc_pkg::CalcWidth-tbbc_pkg::TempWidth){step.temperature[
                        tbbc_pkg::TempWidth-1]}}, step.temperature});
   assign old_ext  = $signed({{(tbbc_pkg::CalcWidth-tbbc_pkg::TempWidth){reading_ff[
                        tbbc_pkg::TempWidth-1]}}, reading_ff});
   assign band_hi  = sp_ext + db_ext;
   assign band_lo  = sp_ext - db_ext;
   assign delta    = temp_ext - old_ext;

   assign above_band     = temp_ext > band_hi;
   assign below_band     = temp_ext < band_lo;
   assign cool_effective = delta < -db_ext;
   assign heat_effective = delta > db_ext;
   assign fault_inc      = fault_ff + 1'b1;

   // Next state for the event at hand.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      reading_in      = reading_ff;
      fault_in        = fault_ff;
      request_measure = 1'b0;
      error_pulse     = 1'b0;
      unique case (state_ff)
         tbbc_pkg::ST_WAIT: begin
            // An expired rest period starts a measurement on any event.
            if (count_ff == '0) begin
               state_in        = tbbc_pkg::ST_CHECK;
               request_measure = 1'b1;
            end else if (step.operation == tbbc_pkg::EV_TICK) begin
               count_in = count_ff - 1'b1;
            end
         end
         tbbc_pkg::ST_CHECK: begin
            if (step.operation == tbbc_pkg::EV_READY) begin
               reading_in = step.temperature;
               if (above_band) begin
                  state_in = tbbc_pkg::ST_COOL;
                  count_in = drive_ticks_ff;
               end else if (below_band) begin
                  state_in = tbbc_pkg::ST_HEAT;
                  count_in = drive_ticks_ff;
               end else begin
                  state_in = tbbc_pkg::ST_WAIT;
                  count_in = rest_ticks_ff;
               end
            end
         end
         tbbc_pkg::ST_COOL, tbbc_pkg::ST_HEAT: begin
            if (step.operation == tbbc_pkg::EV_TICK) begin
               if (count_ff == '0) begin
                  state_in        = (state_ff == tbbc_pkg::ST_COOL) ?
                                    tbbc_pkg::ST_COOL_SENSE : tbbc_pkg::ST_HEAT_SENSE;
                  request_measure = 1'b1;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         tbbc_pkg::ST_COOL_SENSE, tbbc_pkg::ST_HEAT_SENSE: begin
            if (step.operation == tbbc_pkg::EV_READY) begin
               reading_in = step.temperature;
               // Judge the drive period that just ended.
               if ((state_ff == tbbc_pkg::ST_COOL_SENSE) ? cool_effective
                                                         : heat_effective) begin
                  fault_in = '0;
               end else if (fault_ff != tbbc_pkg::FAULT_MAX) begin
                  fault_in    = fault_inc;
                  error_pulse = (fault_inc == error_limit_ff);
               end
               // Keep driving while still outside the band, otherwise recheck.
               if (state_ff == tbbc_pkg::ST_COOL_SENSE && above_band) begin
                  state_in = tbbc_pkg::ST_COOL;
                  count_in = drive_ticks_ff;
               end else if (state_ff == tbbc_pkg::ST_HEAT_SENSE && below_band) begin
                  state_in = tbbc_pkg::ST_HEAT;
                  count_in = drive_ticks_ff;
               end else begin
                  state_in        = tbbc_pkg::ST_CHECK;
                  request_measure = 1'b1;
               end
            end
         end
         default: begin
            state_in = tbbc_pkg::ST_WAIT;
         end
      endcase
   end

   // State advances only when an event is evaluated.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tbbc_pkg::ST_WAIT;
         count_ff   <= '0;
         reading_ff <= '0;
         fault_ff   <= '0;
      end else if (step.valid) begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         reading_ff <= reading_in;
         fault_ff   <= fault_in;
      end
   end

   assign result.mode            = state_in;
   assign result.request_measure = request_measure;
   assign result.error_pulse     = error_pulse;

endmodule

`default_nettype wire

### rtl/core/thermostat_bang_bang_controller_unit.sv
// ----------------------------------------------------------------------------
// Bang-bang thermostat controller
// Six-state heat/cool controller driven by tick and measurement events.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the req_ channel (operation, temperature) with valid and
//   ready; every accepted event yields exactly one word on the rsp_ channel
//   (mode, request_measure, error_pulse).
//   An event accepted at a clock edge is held in the input register and
//   evaluated against the control state once the output register is free;
//   its result is then loaded into the output register, where rsp_valid
//   rises.
//   Throughput is one event per cycle while rsp_ready stays high; the control
//   state is updated by a single compare-and-update pass, so back-to-back
//   events see the state left by the previous one.
//   When the receiver stalls, the result is held and one more event is
//   buffered in the input register; req_ready then drops until the result
//   is taken.
//   Reset clears both register stages and the control state, and loads the
//   default configuration. The csr_ port writes the registers; the user must
//   use it only while no event is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_bang_bang_controller_unit (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  wire [tbbc_pkg::OpWidth-1:0]              req_operation,
   input  wire signed [tbbc_pkg::TempWidth-1:0]     req_temperature,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output logic [tbbc_pkg::ModeWidth-1:0]           rsp_mode,
   output logic                                     rsp_request_measure,
   output logic                                     rsp_error_pulse,
   input  wire                                      csr_write_enable,
   input  wire [tbbc_pkg::CsrIndexWidth-1:0]        csr_index,
   input  wire [tbbc_pkg::CsrDataWidth-1:0]         csr_wdata
);

   logic                                   in_valid_ff, in_valid_in;
   logic [tbbc_pkg::OpWidth-1:0]           in_op_ff;
   logic signed [tbbc_pkg::TempWidth-1:0]  in_temp_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   tbbc_pkg::result_type                   rsp_word_ff;
   tbbc_pkg::step_type                     step;
   tbbc_pkg::result_type                   result;
   logic                                   out_free, fire, in_take;

   // Handshake control for the two register stages.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || fire;
   assign in_take   = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_op_ff   <= req_operation;
         in_temp_ff <= req_temperature;
      end
   end

   // Controller core evaluates the buffered event when the output can take it.
   assign step.valid       = fire;
   assign step.operation   = in_op_ff;
   assign step.temperature = in_temp_ff;

   tbbc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .step             (step),
      .result           (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode            = rsp_word_ff.mode;
   assign rsp_request_measure = rsp_word_ff.request_measure;
   assign rsp_error_pulse     = rsp_word_ff.error_pulse;

endmodule

`default_nettype wire

### rtl/core/tbbc_checker.sv
// ----------------------------------------------------------------------------
// Thermostat controller port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermostat_bang_bang_controller_unit_assert.svh"

module tbbc_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_ready,
   input wire                                   rsp_valid,
   input wire                                   rsp_ready,
   input wire [tbbc_pkg::ModeWidth-1:0]         rsp_mode,
   input wire                                   rsp_request_measure,
   input wire                                   rsp_error_pulse
);

   // A stalled result word holds still.
   `TBBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_mode) && $stable(rsp_request_measure)
      && $stable(rsp_error_pulse), "stalled result changed")

   // The error pulse only comes with the exit of a sense state.
   `TBBC_ASSERT_NOW(a_err_mode, rsp_valid && rsp_error_pulse,
      rsp_mode == tbbc_pkg::ST_COOL || rsp_mode == tbbc_pkg::ST_HEAT
      || rsp_mode == tbbc_pkg::ST_CHECK, "error pulse in wrong mode")

   // A measurement request only comes with a state that waits for a reading.
   `TBBC_ASSERT_NOW(a_req_mode, rsp_valid && rsp_request_measure,
      rsp_mode == tbbc_pkg::ST_CHECK || rsp_mode == tbbc_pkg::ST_COOL_SENSE
      || rsp_mode == tbbc_pkg::ST_HEAT_SENSE, "measurement request in wrong mode")

   // No result can be pending right after reset.
   `TBBC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid && req_ready,
      "pipeline not empty after reset")

endmodule

bind thermostat_bang_bang_controller_unit tbbc_checker u_tbbc_checker (.*);

`default_nettype wire

### sim/thermostat_bang_bang_controller_unit_test.sv
// ----------------------------------------------------------------------------
// Thermostat controller testbench
// Drives event words into the controller under randomized burst and stall
// patterns, predicts every result word in lockstep with the accepted events,
// and compares each returned word field by field across several register sets.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_bang_bang_controller_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tbbc_pkg::*;

   // Block ports.
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [OpWidth-1:0]          req_operation = EV_NONE;
   logic signed [TempWidth-1:0] req_temperature = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [ModeWidth-1:0]        rsp_mode;
   logic                        rsp_request_measure;
   logic                        rsp_error_pulse;
   logic                        csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0]    csr_index = CSR_SETPOINT;
   logic [CsrDataWidth-1:0]     csr_wdata = '0;

   // Predicted controller state and register copies.
   logic [ModeWidth-1:0]        ctl_state = ST_WAIT;
   logic [TickWidth-1:0]        tick_count = '0;
   int                          last_reading = 0;
   int                          prior_reading = 0;
   logic [FaultWidth-1:0]       fault_tally = '0;
   logic signed [TempWidth-1:0] cfg_setpoint = '0;
   logic [DeadbandWidth-1:0]    cfg_deadband = '0;
   logic [TickWidth-1:0]        cfg_drive_ticks = DRIVE_TICKS_RESET;
   logic [TickWidth-1:0]        cfg_rest_ticks = REST_TICKS_RESET;
   logic [FaultWidth-1:0]       cfg_error_limit = ERROR_LIMIT_RESET;

   // Result words predicted but not yet returned, oldest first.
   result_type predicted_words [$];

   // Run bookkeeping.
   int mismatch_count = 0;
   int words_checked = 0;
   int pulses_seen = 0;
   int events_sent = 0;
   int settings_used = 0;
   int fault_peak = 0;
   int noise_pct = 0;
   int fail_pct = 50;
   int burst_left = 0;
   bit valid_up = 1'b0;
   int ready_tick = 0;
   int stall_style = 0;

   // Opening script: one row per event, with a typed result where it is obvious.
   typedef struct packed {
      logic [OpWidth-1:0]          op;
      logic signed [TempWidth-1:0] temp;
      logic                        typed;
      logic [ModeWidth-1:0]        mode;
      logic                        ask;
      logic                        alarm;
   } script_row_type;

   script_row_type opening_rows [26] = '{
      '{EV_NONE,  16'sd0,      1'b1, ST_CHECK,      1'b1, 1'b0},
      '{EV_TICK,  16'sd0,      1'b1, ST_CHECK,      1'b0, 1'b0},
      '{EV_READY, 16'sd0,      1'b1, ST_WAIT,       1'b0, 1'b0},
      '{EV_ENTRY, 16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b1, ST_CHECK,      1'b1, 1'b0},
      '{EV_READY, 16'sh7FFF,   1'b1, ST_COOL,       1'b0, 1'b0},
      '{EV_ENTRY, 16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, -16'sd5,     1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sh7FFF,   1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sd100,    1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sd200,    1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sd300,    1'b1, ST_COOL,       1'b0, 1'b1},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sh8000,   1'b1, ST_HEAT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sh8000,   1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_TICK,  16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sd5,      1'b0, ST_WAIT,       1'b0, 1'b0},
      '{EV_READY, 16'sd0,      1'b0, ST_WAIT,       1'b0, 1'b0}
   };

   thermostat_bang_bang_controller_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_temperature     (req_temperature),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mode            (rsp_mode),
      .rsp_request_measure (rsp_request_measure),
      .rsp_error_pulse     (rsp_error_pulse),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Clock, 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Saturate an integer into the signed sensor range.
   function automatic logic signed [TempWidth-1:0] to_temp(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[TempWidth-1:0];
   endfunction

   // Judge one drive period; returns one when the error pulse fires.
   function automatic logic score_period(bit worked);
      if (worked) begin
         fault_tally = '0;
         return 1'b0;
      end
      if (fault_tally != FAULT_MAX) begin
         fault_tally = fault_tally + 1'b1;
         if (int'(fault_tally) > fault_peak) fault_peak = fault_tally;
         return fault_tally == cfg_error_limit;
      end
      return 1'b0;
   endfunction

   // Advance the predicted controller by one event and return its result word.
   function automatic result_type thermostat_step(logic [OpWidth-1:0] op,
                                                  logic signed [TempWidth-1:0] temp);
      result_type r;
      int hi;
      int lo;
      int db;
      logic ask;
      logic alarm;
      db = int'(cfg_deadband);
      hi = int'(cfg_setpoint) + db;
      lo = int'(cfg_setpoint) - db;
      ask = 1'b0;
      alarm = 1'b0;
      case (ctl_state)
         ST_WAIT: begin
            if (tick_count == '0) begin
               ctl_state = ST_CHECK;
               ask = 1'b1;
            end else if (op == EV_TICK) begin
               tick_count = tick_count - 1'b1;
            end
         end
         ST_CHECK: begin
            if (op == EV_READY) begin
               prior_reading = last_reading;
               last_reading = int'(temp);
               if (last_reading > hi) begin
                  ctl_state = ST_COOL;
                  tick_count = cfg_drive_ticks;
               end else if (last_reading < lo) begin
                  ctl_state = ST_HEAT;
                  tick_count = cfg_drive_ticks;
               end else begin
                  ctl_state = ST_WAIT;
                  tick_count = cfg_rest_ticks;
               end
            end
         end
         ST_COOL, ST_HEAT: begin
            if (op == EV_TICK) begin
               if (tick_count == '0) begin
                  ctl_state = (ctl_state == ST_COOL) ? ST_COOL_SENSE : ST_HEAT_SENSE;
                  ask = 1'b1;
               end else begin
                  tick_count = tick_count - 1'b1;
               end
            end
         end
         ST_COOL_SENSE: begin
            if (op == EV_READY) begin
               prior_reading = last_reading;
               last_reading = int'(temp);
               alarm = score_period(last_reading - prior_reading < -db);
               if (last_reading > hi) begin
                  ctl_state = ST_COOL;
                  tick_count = cfg_drive_ticks;
               end else begin
                  ctl_state = ST_CHECK;
                  ask = 1'b1;
               end
            end
         end
         ST_HEAT_SENSE: begin
            if (op == EV_READY) begin
               prior_reading = last_reading;
               last_reading = int'(temp);
               alarm = score_period(last_reading - prior_reading > db);
               if (last_reading < lo) begin
                  ctl_state = ST_HEAT;
                  tick_count = cfg_drive_ticks;
               end else begin
                  ctl_state = ST_CHECK;
                  ask = 1'b1;
               end
            end
         end
         default: begin
            ctl_state = ST_WAIT;
         end
      endcase
      r.mode = ctl_state;
      r.request_measure = ask;
      r.error_pulse = alarm;
      return r;
   endfunction

   // Mismatch reporting; printing is capped, counting is not.
   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at word %0d: %s got %0d expected %0d",
                  words_checked, what, got, want);
      end
   endtask

   // Offer one event word, wait for acceptance, then record its prediction.
   task automatic send_word(logic [OpWidth-1:0] op, logic signed [TempWidth-1:0] temp,
                            bit typed, result_type want);
      result_type pred;
      if (burst_left == 0) begin
         if (valid_up) begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
         end
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_temperature <= temp;
      valid_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      pred = thermostat_step(op, temp);
      predicted_words.push_back(typed ? want : pred);
      burst_left--;
      events_sent++;
   endtask

   // Stop offering words and let the block empty out.
   task automatic settle_block();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (predicted_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the caller lowers the enable after the last one.
   task automatic put_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all five registers; unused upper bits carry random junk.
   task automatic load_config(logic [15:0] sp, logic [9:0] db, logic [15:0] dt,
                              logic [15:0] rt, logic [7:0] el);
      logic [15:0] db_word;
      logic [15:0] el_word;
      db_word = (16'($urandom()) & 16'hFC00) | {6'b0, db};
      el_word = {8'($urandom()), el};
      put_csr(CSR_SETPOINT, sp);
      put_csr(CSR_DEADBAND, db_word);
      put_csr(CSR_DRIVE_TICKS, dt);
      put_csr(CSR_REST_TICKS, rt);
      put_csr(CSR_ERROR_LIMIT, el_word);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      cfg_setpoint = sp;
      cfg_deadband = db_word[DeadbandWidth-1:0];
      cfg_drive_ticks = dt;
      cfg_rest_ticks = rt;
      cfg_error_limit = el_word[FaultWidth-1:0];
      settings_used++;
   endtask

   // Choose the next event, mostly one that the current state acts on.
   task automatic pick_event(output logic [OpWidth-1:0] op,
                             output logic signed [TempWidth-1:0] temp);
      int hi;
      int lo;
      int db;
      int v;
      bit fail;
      db = int'(cfg_deadband);
      hi = int'(cfg_setpoint) + db;
      lo = int'(cfg_setpoint) - db;
      op = 2'($urandom());
      temp = 16'($urandom());
      fail = $urandom_range(0, 99) < fail_pct;
      if ($urandom_range(0, 99) >= noise_pct) begin
         case (ctl_state)
            ST_WAIT: begin
               if (tick_count != '0 && $urandom_range(0, 9) != 0) op = EV_TICK;
            end
            ST_COOL, ST_HEAT: begin
               if ($urandom_range(0, 9) != 0) op = EV_TICK;
            end
            ST_CHECK: begin
               op = EV_READY;
               case ($urandom_range(0, 3))
                  0: temp = to_temp(hi + int'($urandom_range(1, 3000)));
                  1: temp = to_temp(lo - int'($urandom_range(1, 3000)));
                  2: temp = to_temp(lo + int'($urandom_range(0, 2 * db)));
                  default: ;
               endcase
            end
            ST_COOL_SENSE: begin
               // A stuck cooler keeps the reading above the band when it can.
               op = EV_READY;
               if (fail) begin
                  v = last_reading + int'($urandom_range(0, 50)) - int'($urandom_range(0, db));
                  if (v <= hi) v = last_reading;
               end else begin
                  v = last_reading - db - int'($urandom_range(1, 500));
               end
               temp = to_temp(v);
            end
            ST_HEAT_SENSE: begin
               op = EV_READY;
               if (fail) begin
                  v = last_reading - int'($urandom_range(0, 50)) + int'($urandom_range(0, db));
                  if (v >= lo) v = last_reading;
               end else begin
                  v = last_reading + db + int'($urandom_range(1, 500));
               end
               temp = to_temp(v);
            end
            default: ;
         endcase
      end
   endtask

   // One random segment under one register set.
   task automatic run_phase(logic [15:0] sp, logic [9:0] db, logic [15:0] dt,
                            logic [15:0] rt, logic [7:0] el, int count,
                            int fails, int noise);
      logic [OpWidth-1:0] op;
      logic signed [TempWidth-1:0] temp;
      load_config(sp, db, dt, rt, el);
      fail_pct = fails;
      noise_pct = noise;
      repeat (count) begin
         pick_event(op, temp);
         send_word(op, temp, 1'b0, result_type'(0));
      end
      settle_block();
   endtask

   // Result side: check each accepted word and stall on a changing pattern.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_words.size() == 0) begin
            report_mismatch("word with nothing pending, mode", rsp_mode, 0);
         end else begin
            want = predicted_words.pop_front();
            if (rsp_mode !== want.mode)
               report_mismatch("mode", rsp_mode, want.mode);
            if (rsp_request_measure !== want.request_measure)
               report_mismatch("request_measure", rsp_request_measure, want.request_measure);
            if (rsp_error_pulse !== want.error_pulse)
               report_mismatch("error_pulse", rsp_error_pulse, want.error_pulse);
         end
         if (rsp_error_pulse === 1'b1) pulses_seen++;
         words_checked++;
      end
      ready_tick++;
      if (ready_tick % 300 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 99) >= 30);
         2: rsp_ready <= ($urandom_range(0, 99) >= 80);
         default: rsp_ready <= (ready_tick % 3 == 0);
      endcase
   end

   // Main sequence: reset, opening script, then random segments.
   initial begin
      result_type want;
      script_row_type row;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Short drive and rest periods so the script visits every state quickly.
      load_config(16'd0, 10'd0, 16'd0, 16'd1, 8'd2);
      foreach (opening_rows[i]) begin
         row = opening_rows[i];
         want.mode = row.mode;
         want.request_measure = row.ask;
         want.error_pulse = row.alarm;
         send_word(row.op, row.temp, row.typed, want);
      end
      settle_block();

      // Reset values, then small random sets, then the register extremes.
      run_phase(16'd0, 10'd0, DRIVE_TICKS_RESET, REST_TICKS_RESET, ERROR_LIMIT_RESET,
                200, 50, 10);
      run_phase(16'($urandom()), 10'($urandom_range(0, 60)), 16'($urandom_range(0, 3)),
                16'($urandom_range(0, 3)), 8'd1, 200, 60, 10);
      run_phase(16'h7FFF, 10'd1023, 16'd0, 16'd0, 8'd3, 100, 50, 15);
      run_phase(16'h8000, 10'd1023, 16'd1, 16'd2, 8'd255, 100, 50, 15);
      // A stuck actuator drives the fault counter into saturation.
      run_phase(16'd0, 10'd20, 16'd0, 16'd0, 8'd255, 600, 100, 0);
      // An error limit of zero never pulses.
      run_phase(16'($urandom()), 10'($urandom_range(0, 200)), 16'($urandom_range(0, 2)),
                16'($urandom_range(0, 2)), 8'd0, 150, 80, 10);
      run_phase(16'($urandom()), 10'd0, 16'd0, 16'd0, 8'($urandom_range(1, 4)),
                150, 50, 30);
      // Longest periods last, since their countdowns outlast the segment.
      run_phase(16'($urandom()), 10'd1023, 16'hFFFF, 16'hFFFF, 8'($urandom_range(1, 255)),
                80, 50, 10);

      if (predicted_words.size() != 0)
         report_mismatch("words never returned", predicted_words.size(), 0);
      $display("Covered %0d events under %0d register sets; %0d words checked.",
               events_sent, settings_used, words_checked);
      $display("Error pulses seen: %0d; fault count peaked at %0d.", pulses_seen, fault_peak);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
